@@ design/efa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efa_pkg: shared types and constants of the event frame accumulator
// Command kinds and the command word passed from the front end to the frame
// store engine, plot modes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package efa_pkg;

    // Fixed-point layout of the coordinates (unsigned Q10.6)
    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 6;
    localparam int IPART_W   = COORD_W - FRAC_BITS;
    localparam int WEIGHT_W  = 2 * (FRAC_BITS + 1);

    localparam logic [FRAC_BITS:0] ONE_Q6 = 7'd64;

    localparam int PIXEL_W  = 32;
    localparam int TDELTA_W = 20;
    localparam int MODE_W   = 3;

    localparam logic [PIXEL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;

    // Plot modes
    localparam logic [MODE_W-1:0] MODE_POLARITY = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT16  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT8   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TSURFACE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BILINEAR = 3'd4;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLOT_MODE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_BASE = 1'b1;
    localparam int CFG_DATA_W = 20;

    localparam logic [TDELTA_W-1:0] SURFACE_BASE_RESET = 20'd100000;

    // Input item operations
    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    // Command queue depth between front end and store engine
    localparam int CMD_FIFO_DEPTH = 4;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_POL,
        CMD_CNT16,
        CMD_CNT8,
        CMD_TSURF,
        CMD_ADD
    } cmd_kind_t;

    // One store command; hit is set when the pixel lies inside the frame
    typedef struct packed {
        cmd_kind_t          kind;
        logic               hit;
        logic [PIXEL_W-1:0] arg;
    } cmd_t;

endpackage

@@ design/event_frame_accumulator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_frame_accumulator_top: event-camera frame accumulator
// Accumulates events into a FRAME_WIDTH x FRAME_HEIGHT store of 32-bit pixel
// words and returns (and clears) pixels on read requests.
// ----------------------------------------------------------------------------
// After reset the block clears its frame memory, one word per cycle, over all
// FRAME_WIDTH * FRAME_HEIGHT words (89960 at the default size); s_tready stays
// low during that pass while configuration writes are still taken. Each
// accepted item turns into store commands: one for a read or an in-frame
// polarity, count16, count8 or time-surface event, one per in-frame neighbor
// of a bilinear event, none for an ignored or off-frame event. The store
// engine performs one read-modify-write per cycle on the frame memory unless
// a read waits for the output slot, so throughput is one event per cycle in
// the single-pixel modes; reads are not taken back to back and a bilinear
// event holds intake until its neighbors are issued. A read result passes the
// front-end, queue, memory-read and output registers; a stalled result holds
// the engine only when another read follows; events still flow into the queue.
// Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module event_frame_accumulator_top #(
    parameter int FRAME_WIDTH  = 346,
    parameter int FRAME_HEIGHT = 260
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [efa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [efa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: x_pos[15:0], y_pos[31:16], polarity[32], inside_req[33],
    //        time_delta_us[53:34], zero fill[55:54]
    input  logic [55:0]                       s_tdata,
    // tuser: op[0]
    input  logic [0:0]                        s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: pixel_value[31:0]
    output logic [31:0]                       m_tdata
);
    import efa_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
    localparam int CMD_W  = $bits(cmd_t) + ADDR_W;

    // Configuration registers
    logic [MODE_W-1:0]   plot_mode_reg;
    logic [TDELTA_W-1:0] surface_base_reg;

    // Unpacked input fields
    logic                s_op;
    logic [COORD_W-1:0]  s_x_pos, s_y_pos;
    logic                s_polarity, s_inside_req;
    logic [TDELTA_W-1:0] s_time_delta_us;

    // Front end to queue, queue to store engine
    logic                push, fifo_full, fifo_empty, fifo_pop, clear_active;
    logic [ADDR_W-1:0]   push_addr, fifo_addr;
    cmd_t                push_cmd, fifo_cmd;
    logic [CMD_W-1:0]    fifo_rd_data;

    always_comb begin
        s_op            = s_tuser[0];
        s_x_pos         = s_tdata[15:0];
        s_y_pos         = s_tdata[31:16];
        s_polarity      = s_tdata[32];
        s_inside_req    = s_tdata[33];
        s_time_delta_us = s_tdata[53:34];

        fifo_addr = fifo_rd_data[CMD_W-1:$bits(cmd_t)];
        fifo_cmd  = cmd_t'(fifo_rd_data[$bits(cmd_t)-1:0]);
    end

    // Hold configuration until the next write to its index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plot_mode_reg    <= MODE_POLARITY;
            surface_base_reg <= SURFACE_BASE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PLOT_MODE:    plot_mode_reg    <= cfg_wdata[MODE_W-1:0];
                CFG_SURFACE_BASE: surface_base_reg <= cfg_wdata[TDELTA_W-1:0];
                default: ;
            endcase
        end
    end

    efa_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .clear_active    (clear_active),
        .plot_mode       (plot_mode_reg),
        .surface_base_us (surface_base_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_op            (s_op),
        .s_x_pos         (s_x_pos),
        .s_y_pos         (s_y_pos),
        .s_polarity      (s_polarity),
        .s_inside_req    (s_inside_req),
        .s_time_delta_us (s_time_delta_us),
        .push            (push),
        .push_addr       (push_addr),
        .push_cmd        (push_cmd),
        .fifo_full       (fifo_full)
    );

    efa_cmd_fifo #(
        .DATA_W (CMD_W)
    ) u_cmd_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data ({push_addr, push_cmd}),
        .full    (fifo_full),
        .pop     (fifo_pop),
        .rd_data (fifo_rd_data),
        .empty   (fifo_empty)
    );

    efa_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fifo_empty   (fifo_empty),
        .fifo_addr    (fifo_addr),
        .fifo_cmd     (fifo_cmd),
        .fifo_pop     (fifo_pop),
        .clear_active (clear_active),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

@@ design/efa_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efa_cmd_fifo: command queue between front end and store engine
// Small register FIFO; the head entry is always presented on rd_data.
// ----------------------------------------------------------------------------
module efa_cmd_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rd_data,
    output logic              empty
);
    import efa_pkg::*;

    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb begin
        full    = (count_reg == CNT_W'(CMD_FIFO_DEPTH));
        empty   = (count_reg == '0);
        rd_data = entry_reg[rd_ptr_reg];

        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("command popped from empty queue");

endmodule

@@ design/efa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efa_front: item intake and command generation
// Accepts input items, classifies them by operation and plot mode, drops
// ignored events and issues one store command per read or in-frame pixel.
// ----------------------------------------------------------------------------
module efa_front #(
    parameter  int FRAME_WIDTH  = 346,
    parameter  int FRAME_HEIGHT = 260,
    localparam int ADDR_W       = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            clear_active,
    input  logic [efa_pkg::MODE_W-1:0]      plot_mode,
    input  logic [efa_pkg::TDELTA_W-1:0]    surface_base_us,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_op,
    input  logic [efa_pkg::COORD_W-1:0]     s_x_pos,
    input  logic [efa_pkg::COORD_W-1:0]     s_y_pos,
    input  logic                            s_polarity,
    input  logic                            s_inside_req,
    input  logic [efa_pkg::TDELTA_W-1:0]    s_time_delta_us,
    output logic                            push,
    output logic [ADDR_W-1:0]               push_addr,
    output efa_pkg::cmd_t                   push_cmd,
    input  logic                            fifo_full
);
    import efa_pkg::*;

    logic                 busy_reg, busy_next;
    logic [1:0]           count_reg, count_next;
    logic [1:0]           last_reg;
    cmd_kind_t            kind_reg;
    logic [IPART_W-1:0]   ix_reg, iy_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;
    logic                 pol_reg;
    logic [PIXEL_W-1:0]   tsurf_reg;

    logic                 accept, step, finishing, needs_work;
    cmd_kind_t            in_kind;
    logic [IPART_W:0]     nx, ny;
    logic                 in_frame;
    logic [FRAC_BITS:0]   wx, wy;
    logic [WEIGHT_W-1:0]  weight;

    always_comb begin
        step      = busy_reg && !fifo_full;
        finishing = step && (count_reg == last_reg);
        s_tready  = !clear_active && (!busy_reg || finishing);
        accept    = s_tvalid && s_tready;

        // Classify the incoming item
        if (s_op == OP_READ) begin
            in_kind = CMD_READ;
        end else begin
            case (plot_mode)
                MODE_POLARITY: in_kind = CMD_POL;
                MODE_COUNT16:  in_kind = CMD_CNT16;
                MODE_COUNT8:   in_kind = CMD_CNT8;
                MODE_TSURFACE: in_kind = CMD_TSURF;
                default:       in_kind = CMD_ADD;
            endcase
        end
        needs_work = (s_op == OP_READ) || (s_inside_req && (plot_mode <= MODE_BILINEAR));

        // Neighbor of the current step
        nx       = {1'b0, ix_reg} + (IPART_W + 1)'(count_reg[0]);
        ny       = {1'b0, iy_reg} + (IPART_W + 1)'(count_reg[1]);
        in_frame = (nx < (IPART_W + 1)'(FRAME_WIDTH)) && (ny < (IPART_W + 1)'(FRAME_HEIGHT));

        wx     = count_reg[0] ? {1'b0, fx_reg} : ONE_Q6 - {1'b0, fx_reg};
        wy     = count_reg[1] ? {1'b0, fy_reg} : ONE_Q6 - {1'b0, fy_reg};
        weight = WEIGHT_W'(wx) * WEIGHT_W'(wy);

        push      = step && (in_frame || (kind_reg == CMD_READ));
        push_addr = ADDR_W'(ny) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(nx);

        push_cmd.kind = kind_reg;
        push_cmd.hit  = in_frame;
        case (kind_reg)
            CMD_POL:   push_cmd.arg = {{(PIXEL_W - 1){1'b0}}, pol_reg};
            CMD_TSURF: push_cmd.arg = tsurf_reg;
            CMD_ADD:   push_cmd.arg = {{(PIXEL_W - WEIGHT_W){1'b0}}, weight};
            default:   push_cmd.arg = '0;
        endcase

        busy_next  = busy_reg;
        count_next = count_reg;
        if (accept) begin
            busy_next  = needs_work;
            count_next = '0;
        end else if (finishing) begin
            busy_next = 1'b0;
        end else if (step) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= in_kind;
            last_reg  <= (in_kind == CMD_ADD) ? 2'd3 : 2'd0;
            ix_reg    <= s_x_pos[COORD_W-1:FRAC_BITS];
            iy_reg    <= s_y_pos[COORD_W-1:FRAC_BITS];
            fx_reg    <= s_x_pos[FRAC_BITS-1:0];
            fy_reg    <= s_y_pos[FRAC_BITS-1:0];
            pol_reg   <= s_polarity;
            tsurf_reg <= {{(PIXEL_W - TDELTA_W){1'b0}}, surface_base_us}
                       - {{(PIXEL_W - TDELTA_W){1'b0}}, s_time_delta_us};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (count_reg <= last_reg))
        else $error("neighbor step past last step");

    a_no_intake_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_active |-> !push)
        else $error("command issued during store clearing");

endmodule

@@ design/efa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efa_back: frame store engine
// Owns the frame memory. Clears it after reset, then runs one
// read-modify-write per command with a bypass for back-to-back hits.
// ----------------------------------------------------------------------------
module efa_back #(
    parameter  int FRAME_WIDTH  = 346,
    parameter  int FRAME_HEIGHT = 260,
    localparam int DEPTH        = FRAME_WIDTH * FRAME_HEIGHT,
    localparam int ADDR_W       = $clog2(DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fifo_empty,
    input  logic [ADDR_W-1:0]             fifo_addr,
    input  efa_pkg::cmd_t                 fifo_cmd,
    output logic                          fifo_pop,
    output logic                          clear_active,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [efa_pkg::PIXEL_W-1:0]   m_tdata
);
    import efa_pkg::*;

    logic [PIXEL_W-1:0] mem [DEPTH];

    logic               clear_active_reg, clear_active_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               s2_valid_reg;
    logic [ADDR_W-1:0]  s2_addr_reg;
    cmd_t               s2_cmd_reg;
    logic [PIXEL_W-1:0] rdata_reg;
    logic               wr_valid_reg;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic [PIXEL_W-1:0] wr_data_reg;
    logic               m_valid_reg, m_valid_next;
    logic [PIXEL_W-1:0] m_data_reg;

    logic               slot_free, s2_read, we;
    logic [ADDR_W-1:0]  waddr;
    logic [PIXEL_W-1:0] wdata, cur, new_val;
    logic [PIXEL_W:0]   sum;
    logic [15:0]        hi, lo;

    always_comb begin
        s2_read   = s2_valid_reg && (s2_cmd_reg.kind == CMD_READ);
        slot_free = (!m_valid_reg || m_tready) && !s2_read;
        fifo_pop  = !fifo_empty && !clear_active_reg
                  && ((fifo_cmd.kind != CMD_READ) || slot_free);

        // Bypass the write that landed in the same cycle as this read
        cur = (wr_valid_reg && (wr_addr_reg == s2_addr_reg)) ? wr_data_reg : rdata_reg;

        sum = {1'b0, cur} + {1'b0, s2_cmd_reg.arg};
        hi  = cur[31:16];
        lo  = cur[15:0];
        case (s2_cmd_reg.kind)
            CMD_READ:  new_val = '0;
            CMD_POL: begin
                if (s2_cmd_reg.arg[0]) begin
                    new_val = {(hi == 16'hFFFF) ? hi : hi + 16'd1, lo};
                end else begin
                    new_val = {hi, (lo == 16'hFFFF) ? lo : lo + 16'd1};
                end
            end
            CMD_CNT16: new_val = {16'd0, cur[15:0] + 16'd1};
            CMD_CNT8:  new_val = {24'd0, cur[7:0] + 8'd1};
            CMD_TSURF: new_val = s2_cmd_reg.arg;
            CMD_ADD:   new_val = (sum[PIXEL_W] || sum[PIXEL_W-1]) ? SAT_MAX
                                                                  : sum[PIXEL_W-1:0];
            default:   new_val = cur;
        endcase

        we    = clear_active_reg || (s2_valid_reg && s2_cmd_reg.hit);
        waddr = clear_active_reg ? clr_addr_reg : s2_addr_reg;
        wdata = clear_active_reg ? '0 : new_val;

        clear_active_next = clear_active_reg;
        clr_addr_next     = clr_addr_reg;
        if (clear_active_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clear_active_next = 1'b0;
            end
        end

        m_valid_next = m_valid_reg;
        if (s2_read) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        clear_active = clear_active_reg;
        m_tvalid     = m_valid_reg;
        m_tdata      = m_data_reg;
    end

    // Frame memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (fifo_pop) begin
            rdata_reg <= mem[fifo_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_pop) begin
            s2_addr_reg <= fifo_addr;
            s2_cmd_reg  <= fifo_cmd;
        end
        wr_addr_reg <= waddr;
        wr_data_reg <= wdata;
        if (s2_read) begin
            m_data_reg <= s2_cmd_reg.hit ? cur : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_active_reg <= 1'b1;
            clr_addr_reg     <= '0;
            s2_valid_reg     <= 1'b0;
            wr_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            clear_active_reg <= clear_active_next;
            clr_addr_reg     <= clr_addr_next;
            s2_valid_reg     <= fifo_pop;
            wr_valid_reg     <= we;
            m_valid_reg      <= m_valid_next;
        end
    end

    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_active_reg |-> !fifo_pop)
        else $error("command taken while store is clearing");

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_read |-> !m_valid_reg)
        else $error("read result would overwrite a pending result");

endmodule

@@ tb/event_frame_accumulator_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_frame_accumulator_check: frame store scoreboard
// Watches the configuration port and both stream channels. It keeps a mirror
// of the frame store, updates it for every accepted event, and checks each
// pixel read returned on the result channel against the mirror.
// ----------------------------------------------------------------------------
module event_frame_accumulator_check #(
    parameter int FRAME_WIDTH  = 346,
    parameter int FRAME_HEIGHT = 260
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [efa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [efa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // tdata: x_pos, y_pos, polarity, inside_req, time_delta_us, zero fill
    input  logic [55:0]                      s_tdata,
    // tuser: op
    input  logic [0:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: pixel_value
    input  logic [31:0]                      m_tdata,
    output int                               failures,
    output int                               pending,
    output int                               checked
);
    import efa_pkg::*;

    localparam int PIXELS      = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int PRINT_LIMIT = 20;

    logic [PIXEL_W-1:0]  frame_mirror [PIXELS];
    logic [MODE_W-1:0]   mirror_mode;
    logic [TDELTA_W-1:0] mirror_base;
    logic [PIXEL_W-1:0]  expected_pixels [$];
    int                  mismatch_count = 0;
    int                  compared = 0;

    assign failures = mismatch_count;
    assign checked  = compared;

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic bit on_frame(input int px, input int py);
        return px < FRAME_WIDTH && py < FRAME_HEIGHT;
    endfunction

    // Add one bilinear vote; neighbors off the frame are dropped
    function automatic void add_vote(input int px, input int py, input int weight);
        logic [PIXEL_W:0] total;
        int               addr;
        if (!on_frame(px, py))
            return;
        addr  = py * FRAME_WIDTH + px;
        total = {1'b0, frame_mirror[addr]} + (PIXEL_W + 1)'(weight);
        frame_mirror[addr] = (total > {1'b0, SAT_MAX}) ? SAT_MAX : total[PIXEL_W-1:0];
    endfunction

    function automatic void accumulate_event(input logic [COORD_W-1:0] xq,
                                             input logic [COORD_W-1:0] yq,
                                             input logic pol,
                                             input logic [TDELTA_W-1:0] dt);
        int                 ix, iy, fx, fy, one, addr;
        logic [15:0]        hi, lo;
        logic [PIXEL_W-1:0] word;
        ix  = int'(xq >> FRAC_BITS);
        iy  = int'(yq >> FRAC_BITS);
        fx  = int'(xq[FRAC_BITS-1:0]);
        fy  = int'(yq[FRAC_BITS-1:0]);
        one = int'(ONE_Q6);
        if (mirror_mode == MODE_BILINEAR) begin
            add_vote(ix,     iy,     (one - fx) * (one - fy));
            add_vote(ix + 1, iy,     fx * (one - fy));
            add_vote(ix,     iy + 1, (one - fx) * fy);
            add_vote(ix + 1, iy + 1, fx * fy);
            return;
        end
        if (!on_frame(ix, iy))
            return;
        addr = iy * FRAME_WIDTH + ix;
        word = frame_mirror[addr];
        case (mirror_mode)
            MODE_POLARITY: begin
                // positive count high, negative count low, both saturating
                hi = word[31:16];
                lo = word[15:0];
                if (pol) begin
                    if (hi != 16'hFFFF)
                        hi++;
                end else begin
                    if (lo != 16'hFFFF)
                        lo++;
                end
                frame_mirror[addr] = {hi, lo};
            end
            MODE_COUNT16:  frame_mirror[addr] = {16'h0, word[15:0] + 16'd1};
            MODE_COUNT8:   frame_mirror[addr] = {24'h0, word[7:0] + 8'd1};
            MODE_TSURFACE: frame_mirror[addr] = {12'h0, mirror_base} - {12'h0, dt};
            default: ;
        endcase
    endfunction

    // Read returns the word and clears it; off-frame reads return zero
    function automatic logic [PIXEL_W-1:0] read_and_clear(input logic [COORD_W-1:0] xq,
                                                          input logic [COORD_W-1:0] yq);
        int                 ix, iy, addr;
        logic [PIXEL_W-1:0] word;
        ix = int'(xq >> FRAC_BITS);
        iy = int'(yq >> FRAC_BITS);
        if (!on_frame(ix, iy))
            return '0;
        addr = iy * FRAME_WIDTH + ix;
        word = frame_mirror[addr];
        frame_mirror[addr] = '0;
        return word;
    endfunction

    always @(posedge aclk) begin : watch
        logic [PIXEL_W-1:0] want;
        if (!aresetn) begin
            for (int i = 0; i < PIXELS; i++)
                frame_mirror[i] = '0;
            mirror_mode = MODE_POLARITY;
            mirror_base = SURFACE_BASE_RESET;
            expected_pixels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PLOT_MODE:    mirror_mode = cfg_wdata[MODE_W-1:0];
                    CFG_SURFACE_BASE: mirror_base = cfg_wdata[TDELTA_W-1:0];
                    default: ;
                endcase
            end
            // results first: a read accepted this edge cannot already be out
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("pixel_value %08h with no read waiting",
                                              m_tdata));
                end else begin
                    want = expected_pixels.pop_front();
                    compared++;
                    if (m_tdata !== want)
                        report_mismatch($sformatf("pixel_value got %08h want %08h",
                                                  m_tdata, want));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_READ) begin
                    want = read_and_clear(s_tdata[15:0], s_tdata[31:16]);
                    expected_pixels = {expected_pixels, want};
                end else if (s_tdata[33]) begin
                    accumulate_event(s_tdata[15:0], s_tdata[31:16], s_tdata[32],
                                     s_tdata[53:34]);
                end
            end
        end
        pending <= expected_pixels.size();
    end

endmodule

@@ tb/event_frame_accumulator_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_frame_accumulator_top_test: stimulus and verdict for the accumulator
// Runs a directed pass over every plot mode and the frame edges, then random
// phases that switch mode and surface base while the store keeps its contents,
// under varied sender and receiver stall rates. A scoreboard checks all reads.
// ----------------------------------------------------------------------------
module event_frame_accumulator_top_test;
    import efa_pkg::*;

    localparam int FRAME_WIDTH  = 346;
    localparam int FRAME_HEIGHT = 260;

    // Plot mode values the block leaves unused
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    // Stall profiles of the random phases
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int PRESSURE_PHASE  = 6;
    // Enough for the four-entry command queue full of bilinear events
    localparam int DRAIN_CYCLES    = 48;
    // Covers the clearing pass after reset with a wide margin
    localparam int WATCHDOG_LIMIT  = 250000;

    localparam logic [COORD_W-1:0] CORNER_X = 16'((FRAME_WIDTH - 1) * 64);
    localparam logic [COORD_W-1:0] CORNER_Y = 16'((FRAME_HEIGHT - 1) * 64);

    localparam logic [MODE_W-1:0] PHASE_MODES [RANDOM_PHASES] = '{
        MODE_POLARITY, MODE_COUNT16, MODE_COUNT8, MODE_TSURFACE, MODE_BILINEAR,
        MODE_TSURFACE, MODE_POLARITY, MODE_BILINEAR, MODE_COUNT16, MODE_UNUSED_LO,
        MODE_TSURFACE, MODE_COUNT8, MODE_BILINEAR, MODE_UNUSED_HI
    };

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [55:0]             s_tdata   = '0;
    logic [0:0]              s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [31:0]             m_tdata;

    int failures;
    int pending;
    int checked;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int n_reads        = 0;
    int n_events       = 0;
    int n_settings     = 0;
    logic [TDELTA_W-1:0] cur_base = SURFACE_BASE_RESET;

    always #2 aclk = ~aclk;

    event_frame_accumulator_top #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    event_frame_accumulator_check #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) scoreboard (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .failures  (failures),
        .pending   (pending),
        .checked   (checked)
    );

    // Receiver: stall at the rate of the current phase
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: any transfer or register write restarts the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("event_frame_accumulator_top verification failed");
            $finish;
        end
    end

    // Write both registers; call only while the block is idle
    task automatic set_config(input logic [MODE_W-1:0] mode,
                              input logic [TDELTA_W-1:0] base);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PLOT_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge aclk);
        cfg_index <= CFG_SURFACE_BASE;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_base = base;
        n_settings++;
    endtask

    // Offer one item and hold it until the transfer completes
    task automatic push_item(input logic op,
                             input logic [COORD_W-1:0] xq, yq,
                             input logic pol, ins,
                             input logic [TDELTA_W-1:0] dt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, dt, ins, pol, yq, xq};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (op == OP_READ)
            n_reads++;
        else
            n_events++;
    endtask

    // Drop valid, wait for every read result, then let the engine drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly a hot window at both frame edges so pixels get hit repeatedly
    function automatic logic [COORD_W-1:0] pick_coord(input int extent);
        int         r;
        logic [9:0] ipart;
        r = $urandom_range(99);
        if (r < 70) begin
            if ($urandom_range(1))
                ipart = 10'($urandom_range(4));
            else
                ipart = 10'(extent - $urandom_range(3));
            return {ipart, 6'($urandom)};
        end
        if (r < 85)
            return 16'($urandom);
        return {10'($urandom_range(extent - 1)), 6'($urandom)};
    endfunction

    initial begin : stimulus
        logic                op_r, pol_r, ins_r;
        logic [COORD_W-1:0]  x_r, y_r;
        logic [TDELTA_W-1:0] dt_r, base_r;
        int                  r;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: polarity counts, ignored and off-frame events, corners
        set_config(MODE_POLARITY, SURFACE_BASE_RESET);
        push_item(OP_ACCUMULATE, 16'h0000, 16'h0000, 1'b1, 1'b1, 20'h00000);
        push_item(OP_ACCUMULATE, 16'h0000, 16'h0000, 1'b0, 1'b1, 20'h00000);
        push_item(OP_ACCUMULATE, 16'h0000, 16'h0000, 1'b1, 1'b0, 20'h00000);
        push_item(OP_ACCUMULATE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 20'hFFFFF);
        push_item(OP_ACCUMULATE, CORNER_X, CORNER_Y, 1'b0, 1'b1, 20'hFFFFF);
        push_item(OP_READ,       16'h0000, 16'h0000, 1'b0, 1'b0, 20'h00000);
        push_item(OP_READ,       16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 20'hFFFFF);
        push_item(OP_READ,       CORNER_X, CORNER_Y, 1'b0, 1'b0, 20'h00000);
        settle();

        // Time surface below zero leaves an all-ones word behind
        set_config(MODE_TSURFACE, 20'h00000);
        push_item(OP_ACCUMULATE, 16'h0040, 16'h0000, 1'b0, 1'b1, 20'h00001);
        push_item(OP_ACCUMULATE, 16'h0080, 16'h0000, 1'b0, 1'b1, 20'h00000);
        settle();

        // Both polarity halves saturated
        set_config(MODE_POLARITY, 20'h00000);
        push_item(OP_ACCUMULATE, 16'h0040, 16'h0000, 1'b1, 1'b1, 20'h00000);
        push_item(OP_ACCUMULATE, 16'h0040, 16'h0000, 1'b0, 1'b1, 20'h00000);
        push_item(OP_READ,       16'h0040, 16'h0000, 1'b0, 1'b0, 20'h00000);
        settle();

        set_config(MODE_TSURFACE, 20'h00000);
        push_item(OP_ACCUMULATE, 16'h0040, 16'h0000, 1'b0, 1'b1, 20'h00001);
        settle();

        // Bilinear: sum saturation, neighbors past the edge, fully off frame
        set_config(MODE_BILINEAR, 20'h00000);
        push_item(OP_ACCUMULATE, 16'h0040, 16'h0000, 1'b0, 1'b1, 20'h00000);
        push_item(OP_ACCUMULATE, CORNER_X | 16'd32, CORNER_Y | 16'd17, 1'b1, 1'b1, 20'h0);
        push_item(OP_ACCUMULATE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 20'h00000);
        push_item(OP_READ,       16'h0040, 16'h0000, 1'b0, 1'b0, 20'h00000);
        push_item(OP_READ,       CORNER_X, CORNER_Y, 1'b0, 1'b0, 20'h00000);
        settle();

        set_config(MODE_COUNT16, 20'h00000);
        push_item(OP_ACCUMULATE, 16'h00C0, 16'h0000, 1'b0, 1'b1, 20'h00000);
        push_item(OP_READ,       16'h00C0, 16'h0000, 1'b0, 1'b0, 20'h00000);
        settle();

        set_config(MODE_COUNT8, 20'h00000);
        push_item(OP_ACCUMULATE, 16'h00C0, 16'h0000, 1'b0, 1'b1, 20'h00000);
        push_item(OP_READ,       16'h00C0, 16'h0000, 1'b0, 1'b0, 20'h00000);
        settle();

        // Unused mode changes nothing
        set_config(MODE_UNUSED_LO, 20'h00000);
        push_item(OP_ACCUMULATE, 16'h00C0, 16'h0000, 1'b1, 1'b1, 20'h00000);
        push_item(OP_READ,       16'h00C0, 16'h0000, 1'b0, 1'b0, 20'h00000);
        settle();

        // Random phases: the store keeps its contents across mode switches,
        // so leftovers from one mode feed wrap and saturation in the next
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                IDLE_NONE: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                IDLE_SENDER: begin
                    send_idle_pct = 56;
                    recv_stall_pct <= 0;
                end
                IDLE_RECEIVER: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 56;
                end
                default: begin
                    send_idle_pct = 9;
                    recv_stall_pct <= 9;
                end
            endcase
            case (p % 3)
                0:       base_r = 20'h00000;
                1:       base_r = 20'hFFFFF;
                default: base_r = 20'($urandom);
            endcase
            set_config(PHASE_MODES[p], base_r);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // hold off once mid-phase until every read has returned
                if (p == PRESSURE_PHASE && k == ITEMS_PER_PHASE / 2) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (pending != 0)
                        @(posedge aclk);
                end
                op_r  = ($urandom_range(99) < 30) ? OP_READ : OP_ACCUMULATE;
                x_r   = pick_coord(FRAME_WIDTH);
                y_r   = pick_coord(FRAME_HEIGHT);
                pol_r = 1'($urandom);
                ins_r = ($urandom_range(99) < 88);
                // near the base the surface word lands on zero or all ones
                r = $urandom_range(99);
                if (r < 60)
                    dt_r = 20'($urandom);
                else if (r < 80)
                    dt_r = cur_base + 20'd1;
                else
                    dt_r = cur_base;
                push_item(op_r, x_r, y_r, pol_r, ins_r, dt_r);
            end
            settle();
        end

        $display("Summary: %0d events and %0d pixel reads over %0d mode/base settings,",
                 n_events, n_reads, n_settings);
        $display("         %0d read results compared against the frame mirror", checked);
        if (failures == 0)
            $display("event_frame_accumulator_top verification clean");
        else
            $display("event_frame_accumulator_top verification failed");
        $finish;
    end

endmodule
